// ----- rtl/mrm_pkg.sv -----
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types, codes and the CRC-16 byte step for the Modbus RTU master link.
// ----------------------------------------------------------------------------
package mrm_pkg;

    localparam int MAX_REGS    = 32;
    localparam int OP_W        = 3;
    localparam int SEL_W       = 3;
    localparam int ADDR_W      = 16;
    localparam int CNT_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int TICK_W      = 24;
    localparam int CRC_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;
    localparam int STEP_W      = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY      = 16'hA001;
    localparam logic [BYTE_W-1:0] FC_READ       = 8'h03;
    localparam logic [BYTE_W-1:0] FC_WRITE      = 8'h10;
    localparam logic [BYTE_W-1:0] BYTE_ZERO     = 8'h00;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd200000;
    localparam logic [TICK_W-1:0] TICK_MAX      = 24'hFFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_TABLE = 1'd0,
        CFG_TIMEOUT     = 1'd1
    } t_cfg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_START_READ  = 3'd0,
        OP_START_WRITE = 3'd1,
        OP_PAYLOAD     = 3'd2,
        OP_RX_BYTE     = 3'd3,
        OP_TICK        = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_PAYLOAD    = 2'd1,
        PH_READ_WAIT  = 2'd2,
        PH_WRITE_WAIT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_RX     = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_CRC_ERR = 3'd2,
        ST_NO_ACK  = 3'd3,
        ST_BUSY    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        JOB_STATUS      = 3'd0,
        JOB_START_READ  = 3'd1,
        JOB_START_WRITE = 3'd2,
        JOB_PAYLOAD     = 3'd3,
        JOB_RX          = 3'd4
    } t_job_kind;

    // One classified item, queued between front and back
    typedef struct packed {
        t_job_kind          kind;
        t_status            status;
        logic [BYTE_W-1:0]  slave;
        logic [ADDR_W-1:0]  addr;
        logic [CNT_W-1:0]   cnt;
        logic [BYTE_W-1:0]  data;
        logic               final_beat;
        logic [LEN_W-1:0]   len;
    } t_job;

    // CRC-16, reflected poly, one byte
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/mrm_ifs.sv -----
// ----------------------------------------------------------------------------
// mrm_ifs
// Valid/ready channel interfaces for request items and result beats.
// ----------------------------------------------------------------------------
interface mrm_req_if;
    logic                         valid;
    logic                         ready;
    logic [mrm_pkg::OP_W-1:0]     operation;
    logic [mrm_pkg::SEL_W-1:0]    slave_select;
    logic [mrm_pkg::ADDR_W-1:0]   register_address;
    logic [mrm_pkg::CNT_W-1:0]    register_count;
    logic [mrm_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, operation, slave_select, register_address,
                    register_count, data_byte, input ready);
    modport sink   (input valid, operation, slave_select, register_address,
                    register_count, data_byte, output ready);
endinterface

interface mrm_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   result_kind;
    logic [mrm_pkg::BYTE_W-1:0]   byte_value;
    logic [2:0]                   status;
    logic [mrm_pkg::LEN_W-1:0]    response_length;
    logic                         last;

    modport source (output valid, result_kind, byte_value, status, response_length,
                    last, input ready);
    modport sink   (input valid, result_kind, byte_value, status, response_length,
                    last, output ready);
endinterface

// ----- rtl/modbus_rtu_master_link_top.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_master_link_top
// Modbus RTU master link: read (0x03) and write-multiple (0x10) requests with
// CRC-16 framing, reply pass-through and checking, tick-driven timeout.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Beat contents
//  i_req     in   valid/ready    operation, slave_select, register_address,
//                                register_count, data_byte
//  o_rsp     out  valid/ready    result_kind, byte_value, status,
//                                response_length, last
//  i_cfg_*   in   write enable   register index, 64-bit write data
//
//  Cycles: the front takes one item per cycle while the job queue has room.
//  The back sends one result beat per cycle while the output is not stalled;
//  beats per item: start read 8, start write 7, payload byte 1 (3 on the
//  last one), line byte 1 (2 on the last one), status 1, ignored items 0.
//  The back's beat sequencer sets the sustained rate.
//  Reset: synchronous, active low; no clearing pass.
//  Stalls: the output register and the four-deep queue let either side stall
//  on its own; a full queue drops i_req.ready.
//
module modbus_rtu_master_link_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mrm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mrm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mrm_req_if.sink                         i_req,
    mrm_rsp_if.source                       o_rsp
);
    import mrm_pkg::*;

    // front -> queue
    logic  push;
    t_job  push_job;
    logic  q_full;

    // queue -> back
    logic  q_valid;
    t_job  q_job;
    logic  pop;

    // Front: decodes each beat, keeps the phase, counters and the slave
    // table, and turns the beat into at most one job.
    mrm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Jobs in order; decouples item intake from beat output.
    mrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    // Back: frames requests, runs transmit and receive CRCs, and emits the
    // result beats through a registered output stage.
    mrm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

// ----- rtl/mrm_front.sv -----
// ----------------------------------------------------------------------------
// mrm_front
// Accepts items, tracks the transaction phase and queues classified jobs.
// ----------------------------------------------------------------------------
module mrm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mrm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mrm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mrm_req_if.sink                         i_req,
    input  logic                            i_q_full,
    output logic                            o_push,
    output mrm_pkg::t_job                   o_job
);
    import mrm_pkg::*;

    logic [CFG_DATA_W-1:0] r_table;
    logic [TICK_W-1:0]     r_timeout;
    t_phase                r_phase, n_phase;
    logic [LEN_W-1:0]      r_rem, n_rem;
    logic [LEN_W-1:0]      r_exp, n_exp;
    logic [TICK_W-1:0]     r_elapsed, n_elapsed;
    logic [BYTE_W-1:0]     r_slave, n_slave;

    logic                  accept;
    t_op                   op;
    logic [CNT_W-1:0]      cnt_c;
    logic [BYTE_W-1:0]     sel_addr;
    logic [LEN_W-1:0]      two_cnt;
    logic [LEN_W-1:0]      rd_len;
    logic [LEN_W-1:0]      rem_dec;
    logic [TICK_W-1:0]     tick_cnt;
    logic                  timed_out;

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && i_req.ready;
    assign op          = t_op'(i_req.operation);

    always_comb begin
        cnt_c = i_req.register_count;
        if (cnt_c == '0) begin
            cnt_c = CNT_W'(1);
        end else if (cnt_c > CNT_W'(MAX_REGS)) begin
            cnt_c = CNT_W'(MAX_REGS);
        end
    end

    assign sel_addr  = r_table[{i_req.slave_select, 3'b000} +: BYTE_W];
    assign two_cnt   = {cnt_c, 1'b0};
    assign rd_len    = two_cnt + LEN_W'(5);
    assign rem_dec   = (r_rem != '0) ? r_rem - LEN_W'(1) : r_rem;
    assign tick_cnt  = (r_elapsed != TICK_MAX) ? r_elapsed + TICK_W'(1) : r_elapsed;
    assign timed_out = tick_cnt > r_timeout;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (op)
                OP_START_READ: begin
                    if (r_phase == PH_IDLE) n_phase = PH_READ_WAIT;
                end
                OP_START_WRITE: begin
                    if (r_phase == PH_IDLE) n_phase = PH_PAYLOAD;
                end
                OP_PAYLOAD: begin
                    if (r_phase == PH_PAYLOAD && rem_dec == '0) n_phase = PH_WRITE_WAIT;
                end
                OP_RX_BYTE: begin
                    if (r_phase == PH_READ_WAIT && rem_dec == '0) begin
                        n_phase = PH_IDLE;
                    end else if (r_phase == PH_WRITE_WAIT) begin
                        n_phase = PH_IDLE;
                    end
                end
                OP_TICK: begin
                    if ((r_phase inside {PH_READ_WAIT, PH_WRITE_WAIT}) && timed_out) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    // jobs and counters
    always_comb begin
        o_push    = 1'b0;
        o_job     = '0;
        n_rem     = r_rem;
        n_exp     = r_exp;
        n_elapsed = r_elapsed;
        n_slave   = r_slave;
        if (accept) begin
            case (op)
                OP_START_READ, OP_START_WRITE: begin
                    o_push = 1'b1;
                    if (r_phase != PH_IDLE) begin
                        o_job.kind   = JOB_STATUS;
                        o_job.status = ST_BUSY;
                    end else begin
                        o_job.kind  = (op == OP_START_READ) ? JOB_START_READ : JOB_START_WRITE;
                        o_job.slave = sel_addr;
                        o_job.addr  = i_req.register_address;
                        o_job.cnt   = cnt_c;
                        n_slave     = sel_addr;
                        if (op == OP_START_READ) begin
                            n_exp     = rd_len;
                            n_rem     = rd_len;
                            n_elapsed = '0;
                        end else begin
                            n_rem = two_cnt;
                        end
                    end
                end
                OP_PAYLOAD: begin
                    if (r_phase == PH_PAYLOAD) begin
                        o_push           = 1'b1;
                        o_job.kind       = JOB_PAYLOAD;
                        o_job.data       = i_req.data_byte;
                        o_job.final_beat = (rem_dec == '0);
                        n_rem            = rem_dec;
                        if (rem_dec == '0) n_elapsed = '0;
                    end
                end
                OP_RX_BYTE: begin
                    if (r_phase == PH_READ_WAIT) begin
                        o_push           = 1'b1;
                        o_job.kind       = JOB_RX;
                        o_job.data       = i_req.data_byte;
                        o_job.final_beat = (rem_dec == '0);
                        o_job.len        = r_exp;
                        n_rem            = rem_dec;
                    end else if (r_phase == PH_WRITE_WAIT) begin
                        o_push       = 1'b1;
                        o_job.kind   = JOB_STATUS;
                        o_job.status = (i_req.data_byte == r_slave) ? ST_OK : ST_NO_ACK;
                    end
                end
                OP_TICK: begin
                    if (r_phase inside {PH_READ_WAIT, PH_WRITE_WAIT}) begin
                        n_elapsed = tick_cnt;
                        if (timed_out) begin
                            o_push       = 1'b1;
                            o_job.kind   = JOB_STATUS;
                            o_job.status = ST_TIMEOUT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_rem     <= '0;
            r_exp     <= '0;
            r_elapsed <= '0;
            r_slave   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_rem     <= n_rem;
            r_exp     <= n_exp;
            r_elapsed <= n_elapsed;
            r_slave   <= n_slave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table   <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SLAVE_TABLE: r_table   <= i_cfg_data;
                CFG_TIMEOUT:     r_timeout <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    a_payload_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_rem != '0)
        else $error("payload phase with nothing left to collect");

    a_read_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_READ_WAIT |-> (r_rem != '0 && r_rem <= r_exp))
        else $error("read reply count out of step with expected length");

    a_rx_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.kind == JOB_RX && o_job.final_beat) |=> r_phase == PH_IDLE)
        else $error("final reply byte did not close the transaction");

endmodule

// ----- rtl/mrm_queue.sv -----
// ----------------------------------------------------------------------------
// mrm_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module mrm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mrm_pkg::t_job   i_job,
    output logic            o_full,
    output logic            o_valid,
    output mrm_pkg::t_job   o_job,
    input  logic            i_pop
);
    import mrm_pkg::*;

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/mrm_back.sv -----
// ----------------------------------------------------------------------------
// mrm_back
// Expands queued jobs into result beats, one per cycle unless stalled; owns both CRCs.
// ----------------------------------------------------------------------------
module mrm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mrm_pkg::t_job   i_job,
    output logic            o_pop,
    mrm_rsp_if.source       o_rsp
);
    import mrm_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [CRC_W-1:0]  r_tx_crc, r_rx_crc;
    logic              r_o_valid;
    t_kind             r_o_kind;
    logic [BYTE_W-1:0] r_o_byte;
    t_status           r_o_status;
    logic [LEN_W-1:0]  r_o_len;
    logic              r_o_last;

    logic              can_emit, fire;
    t_kind             b_kind;
    logic [BYTE_W-1:0] b_byte;
    t_status           b_status;
    logic [LEN_W-1:0]  b_len;
    logic              b_last;
    logic              tx_upd, tx_restart, rx_upd, rx_restart;
    logic [CRC_W-1:0]  tx_base, tx_next, rx_next;

    assign can_emit = !r_o_valid || o_rsp.ready;
    assign fire     = i_valid && can_emit;
    assign o_pop    = fire && b_last;

    always_comb begin
        b_kind     = KIND_TX;
        b_byte     = BYTE_ZERO;
        b_status   = ST_OK;
        b_len      = '0;
        b_last     = 1'b0;
        tx_upd     = 1'b0;
        tx_restart = 1'b0;
        rx_upd     = 1'b0;
        rx_restart = 1'b0;
        case (i_job.kind)
            JOB_STATUS: begin
                b_kind   = KIND_STATUS;
                b_status = i_job.status;
                b_last   = 1'b1;
            end
            JOB_START_READ, JOB_START_WRITE: begin
                tx_upd = 1'b1;
                case (r_step)
                    3'd0: begin
                        b_byte     = i_job.slave;
                        tx_restart = 1'b1;
                        rx_restart = (i_job.kind == JOB_START_READ);
                    end
                    3'd1: b_byte = (i_job.kind == JOB_START_READ) ? FC_READ : FC_WRITE;
                    3'd2: b_byte = i_job.addr[15:8];
                    3'd3: b_byte = i_job.addr[7:0];
                    3'd4: b_byte = BYTE_ZERO;
                    3'd5: b_byte = BYTE_W'(i_job.cnt);
                    3'd6: begin
                        if (i_job.kind == JOB_START_READ) begin
                            b_byte = r_tx_crc[7:0];
                            tx_upd = 1'b0;
                        end else begin
                            // byte count of the write payload
                            b_byte = BYTE_W'({i_job.cnt, 1'b0});
                            b_last = 1'b1;
                        end
                    end
                    default: begin
                        b_byte = r_tx_crc[15:8];
                        tx_upd = 1'b0;
                        b_last = 1'b1;
                    end
                endcase
            end
            JOB_PAYLOAD: begin
                case (r_step)
                    3'd0: begin
                        b_byte = i_job.data;
                        tx_upd = 1'b1;
                        b_last = !i_job.final_beat;
                    end
                    3'd1: b_byte = r_tx_crc[7:0];
                    default: begin
                        b_byte = r_tx_crc[15:8];
                        b_last = 1'b1;
                    end
                endcase
            end
            JOB_RX: begin
                if (r_step == '0) begin
                    b_kind = KIND_RX;
                    b_byte = i_job.data;
                    rx_upd = 1'b1;
                    b_last = !i_job.final_beat;
                end else begin
                    // CRC over the whole reply, its own CRC included, ends at zero
                    b_kind = KIND_STATUS;
                    b_last = 1'b1;
                    if (r_rx_crc == '0) begin
                        b_status = ST_OK;
                        b_len    = i_job.len;
                    end else begin
                        b_status = ST_CRC_ERR;
                    end
                end
            end
            default: b_last = 1'b1;
        endcase
    end

    assign tx_base = tx_restart ? CRC_INIT : r_tx_crc;
    assign tx_next = crc16_byte(tx_base, b_byte);
    assign rx_next = crc16_byte(r_rx_crc, b_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_tx_crc  <= CRC_INIT;
            r_rx_crc  <= CRC_INIT;
            r_o_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_step    <= b_last ? '0 : r_step + STEP_W'(1);
                r_o_valid <= 1'b1;
                if (tx_upd)     r_tx_crc <= tx_next;
                if (rx_upd)     r_rx_crc <= rx_next;
                if (rx_restart) r_rx_crc <= CRC_INIT;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_kind   <= b_kind;
            r_o_byte   <= b_byte;
            r_o_status <= b_status;
            r_o_len    <= b_len;
            r_o_last   <= b_last;
        end
    end

    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.result_kind     = r_o_kind;
    assign o_rsp.byte_value      = r_o_byte;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.response_length = r_o_len;
    assign o_rsp.last            = r_o_last;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for modbus_rtu_master_link_top. Directed items, then
// random read and write exchanges with line replies, ticks and stray items
// under several register settings and idle patterns. Every result beat is
// checked against a bench model of the link.
// ----------------------------------------------------------------------------
module tb;
    import mrm_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 20;    // queue depth plus output register, with margin
    localparam int SEG_ITEMS   = 31;
    localparam int SEGMENTS    = 9;
    localparam int REPORT_MAX  = 10;
    localparam int TMO_WINDOW  = 60;    // timeouts are only provoked at or below this
    localparam int CNT_TOP     = (1 << CNT_W) - 1;
    localparam int OP_TOP      = (1 << OP_W) - 1;

    // One request item as it goes on the bus
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SEL_W-1:0]  sel;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  cnt;
        logic [BYTE_W-1:0] data;
    } t_link_req;

    // One result beat
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        t_status           st;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_link_beat;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mrm_req_if req_ch();
    mrm_rsp_if rsp_ch();

    modbus_rtu_master_link_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Bench copy of the link state and registers
    t_phase              link_phase;
    logic [CRC_W-1:0]    tx_crc;
    logic [CRC_W-1:0]    rx_crc;
    logic [LEN_W-1:0]    bytes_left;
    logic [LEN_W-1:0]    reply_len;
    logic [TICK_W-1:0]   ticks_seen;
    logic [BYTE_W-1:0]   cur_slave;
    logic [CFG_DATA_W-1:0] slave_table;
    logic [TICK_W-1:0]   timeout_limit;

    t_link_req   pending_items[$];   // items not yet accepted
    t_link_beat  expected_beats[$];  // beats predicted, not yet seen
    t_link_beat  step_beats[$];      // beats of the item being predicted
    logic [BYTE_W-1:0] reply_bytes[$];

    t_link_beat  seen_beat;
    t_link_beat  due_beat;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches   = 0;
    int useful_items = 0;
    int cycles       = 0;

    // ------------------------------------------------------------------------
    // Bench model
    // ------------------------------------------------------------------------
    // CRC-16, reflected 0xA001, one byte
    function automatic logic [CRC_W-1:0] crc16_step(logic [CRC_W-1:0] crc,
                                                    logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] cnt);
        if (cnt == '0) return CNT_W'(1);
        if (cnt > MAX_REGS) return CNT_W'(MAX_REGS);
        return cnt;
    endfunction

    function automatic void add_beat(t_kind kind, logic [BYTE_W-1:0] value,
                                     t_status st, logic [LEN_W-1:0] len);
        t_link_beat b;
        b.kind  = kind;
        b.value = value;
        b.st    = st;
        b.len   = len;
        b.last  = 1'b0;
        step_beats.insert(step_beats.size(), b);
    endfunction

    // Request byte that also feeds the transmit CRC
    function automatic void add_tx(logic [BYTE_W-1:0] value);
        tx_crc = crc16_step(tx_crc, value);
        add_beat(KIND_TX, value, ST_OK, '0);
    endfunction

    // Work out the beats one accepted item causes and queue them
    function automatic void predict_link_beats(t_link_req it);
        logic [CNT_W-1:0] regs;
        regs = clamp_count(it.cnt);
        step_beats.delete();
        case (it.op)
            OP_START_READ, OP_START_WRITE: begin
                if (link_phase != PH_IDLE) begin
                    add_beat(KIND_STATUS, '0, ST_BUSY, '0);
                end else begin
                    cur_slave = slave_table[8*it.sel +: 8];
                    tx_crc    = CRC_INIT;
                    add_tx(cur_slave);
                    add_tx(it.op == OP_START_READ ? FC_READ : FC_WRITE);
                    add_tx(it.addr[15:8]);
                    add_tx(it.addr[7:0]);
                    add_tx(BYTE_ZERO);
                    add_tx({2'b00, regs});
                    if (it.op == OP_START_READ) begin
                        // CRC bytes go out without feeding the CRC
                        add_beat(KIND_TX, tx_crc[7:0], ST_OK, '0);
                        add_beat(KIND_TX, tx_crc[15:8], ST_OK, '0);
                        reply_len  = LEN_W'(2 * regs + 5);
                        bytes_left = reply_len;
                        rx_crc     = CRC_INIT;
                        ticks_seen = '0;
                        link_phase = PH_READ_WAIT;
                    end else begin
                        add_tx({1'b0, regs, 1'b0});
                        bytes_left = {regs, 1'b0};
                        link_phase = PH_PAYLOAD;
                    end
                end
            end
            OP_PAYLOAD: begin
                if (link_phase == PH_PAYLOAD) begin
                    add_tx(it.data);
                    if (bytes_left != '0) bytes_left--;
                    if (bytes_left == '0) begin
                        add_beat(KIND_TX, tx_crc[7:0], ST_OK, '0);
                        add_beat(KIND_TX, tx_crc[15:8], ST_OK, '0);
                        ticks_seen = '0;
                        link_phase = PH_WRITE_WAIT;
                    end
                end
            end
            OP_RX_BYTE: begin
                if (link_phase == PH_READ_WAIT) begin
                    add_beat(KIND_RX, it.data, ST_OK, '0);
                    rx_crc = crc16_step(rx_crc, it.data);
                    if (bytes_left != '0) bytes_left--;
                    if (bytes_left == '0) begin
                        // whole reply, CRC included, must leave zero
                        if (rx_crc == '0) add_beat(KIND_STATUS, '0, ST_OK, reply_len);
                        else add_beat(KIND_STATUS, '0, ST_CRC_ERR, '0);
                        link_phase = PH_IDLE;
                    end
                end else if (link_phase == PH_WRITE_WAIT) begin
                    // acknowledge byte itself is not passed on
                    add_beat(KIND_STATUS, '0,
                             it.data == cur_slave ? ST_OK : ST_NO_ACK, '0);
                    link_phase = PH_IDLE;
                end
            end
            OP_TICK: begin
                if (link_phase == PH_READ_WAIT || link_phase == PH_WRITE_WAIT) begin
                    if (ticks_seen != TICK_MAX) ticks_seen++;
                    if (ticks_seen > timeout_limit) begin
                        add_beat(KIND_STATUS, '0, ST_TIMEOUT, '0);
                        link_phase = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
        if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
        foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_item(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel,
                                       logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] cnt,
                                       logic [BYTE_W-1:0] data);
        t_link_req it;
        it = '{op, sel, addr, cnt, data};
        pending_items.insert(pending_items.size(), it);
        if (op <= OP_TICK) useful_items++;
    endfunction

    // Item whose select, address and count do not matter
    function automatic void queue_filler(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data);
        queue_item(op, SEL_W'($urandom), ADDR_W'($urandom), CNT_W'($urandom), data);
    endfunction

    // Append one byte to the reply being built
    function automatic void add_reply(logic [BYTE_W-1:0] b);
        reply_bytes.insert(reply_bytes.size(), b);
    endfunction

    // Append CRC, low byte first, to the reply being built
    function automatic void close_reply();
        logic [CRC_W-1:0] c;
        c = CRC_INIT;
        foreach (reply_bytes[i]) c = crc16_step(c, reply_bytes[i]);
        add_reply(c[7:0]);
        add_reply(c[15:8]);
    endfunction

    // Mostly small counts, some up to the maximum, a few out of range
    function automatic logic [CNT_W-1:0] pick_count();
        int p;
        p = $urandom_range(0, 99);
        if (p < 82) return CNT_W'($urandom_range(1, 4));
        if (p < 92) return CNT_W'($urandom_range(5, MAX_REGS));
        if (p < 96) return '0;
        return CNT_W'($urandom_range(MAX_REGS + 1, CNT_TOP));
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SLAVE_TABLE) slave_table = value;
        else timeout_limit = value[TICK_W-1:0];
    endtask

    // Wait until all items are in and all beats out, then let the pipe empty
    task automatic settle_link();
        while (pending_items.size() != 0 || req_ch.valid || expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Random exchanges: mostly well-formed reads and writes, some stray items
    task automatic queue_random_traffic(input int n_items);
        int goal;
        int pick;
        int k;
        int keep;
        bit tmo_room;
        logic [SEL_W-1:0]  sel;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  regs;
        logic [BYTE_W-1:0] slave;
        goal = useful_items + n_items;
        while (useful_items < goal) begin
            pick     = $urandom_range(0, 99);
            sel      = SEL_W'($urandom);
            cnt      = pick_count();
            regs     = clamp_count(cnt);
            slave    = slave_table[8*sel +: 8];
            tmo_room = (timeout_limit <= TMO_WINDOW);
            if (pick < 40) begin
                // read: request, then the slave's reply
                queue_item(OP_START_READ, sel, ADDR_W'($urandom), cnt, 8'($urandom));
                reply_bytes.delete();
                add_reply(slave);
                add_reply(FC_READ);
                add_reply({1'b0, regs, 1'b0});
                repeat (2 * regs) add_reply(8'($urandom));
                close_reply();
                if ($urandom_range(0, 99) < 15) begin
                    k = $urandom_range(0, reply_bytes.size() - 1);
                    reply_bytes[k] = reply_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
                end
                if (tmo_room && $urandom_range(0, 99) < 20) begin
                    // short reply, timer runs out
                    keep = $urandom_range(0, reply_bytes.size() - 1);
                    while (reply_bytes.size() > keep) void'(reply_bytes.pop_back());
                    foreach (reply_bytes[i]) queue_filler(OP_RX_BYTE, reply_bytes[i]);
                    repeat (timeout_limit + 1) queue_filler(OP_TICK, 8'($urandom));
                end else begin
                    foreach (reply_bytes[i]) begin
                        k = $urandom_range(0, 99);
                        if (k < 5) queue_filler(OP_TICK, 8'($urandom));
                        else if (k < 8)
                            queue_filler(OP_W'($urandom_range(OP_START_READ, OP_START_WRITE)),
                                         8'($urandom));
                        queue_filler(OP_RX_BYTE, reply_bytes[i]);
                    end
                end
            end else if (pick < 75) begin
                // write: request, payload, acknowledge or silence
                queue_item(OP_START_WRITE, sel, ADDR_W'($urandom), cnt, 8'($urandom));
                repeat (2 * regs) begin
                    k = $urandom_range(0, 99);
                    if (k < 3) queue_filler(OP_RX_BYTE, 8'($urandom));
                    else if (k < 6) queue_filler(OP_TICK, 8'($urandom));
                    else if (k < 8)
                        queue_filler(OP_W'($urandom_range(OP_START_READ, OP_START_WRITE)),
                                     8'($urandom));
                    queue_filler(OP_PAYLOAD, 8'($urandom));
                end
                k = $urandom_range(0, 99);
                if (tmo_room && k < 20) begin
                    repeat (timeout_limit + 1) queue_filler(OP_TICK, 8'($urandom));
                end else begin
                    repeat ($urandom_range(0, timeout_limit < 3 ? timeout_limit : 3))
                        queue_filler(OP_TICK, 8'($urandom));
                    queue_filler(OP_RX_BYTE, k < 75 ? slave : 8'($urandom));
                end
            end else begin
                // stray item, now and then a lone start
                if ($urandom_range(0, 19) == 0)
                    queue_filler(OP_W'($urandom_range(OP_START_READ, OP_START_WRITE)),
                                 8'($urandom));
                else
                    queue_filler(OP_W'($urandom_range(OP_PAYLOAD, OP_TOP)), 8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver: presents the head of the pending queue, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predict_link_beats(pending_items.pop_front());
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_items.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    req_ch.valid            <= 1'b1;
                    req_ch.operation        <= pending_items[0].op;
                    req_ch.slave_select     <= pending_items[0].sel;
                    req_ch.register_address <= pending_items[0].addr;
                    req_ch.register_count   <= pending_items[0].cnt;
                    req_ch.data_byte        <= pending_items[0].data;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure, each beat checked against the oldest
    // expectation
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen_beat.kind  = t_kind'(rsp_ch.result_kind);
                seen_beat.value = rsp_ch.byte_value;
                seen_beat.st    = t_status'(rsp_ch.status);
                seen_beat.len   = rsp_ch.response_length;
                seen_beat.last  = rsp_ch.last;
                if (expected_beats.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("unexpected beat: kind=%0d byte=%02h st=%0d len=%0d last=%0d",
                                 seen_beat.kind, seen_beat.value, seen_beat.st,
                                 seen_beat.len, seen_beat.last);
                    mismatches++;
                end else begin
                    due_beat = expected_beats.pop_front();
                    if (seen_beat !== due_beat) begin
                        if (mismatches < REPORT_MAX) begin
                            $display("beat mismatch: exp kind=%0d byte=%02h st=%0d len=%0d last=%0d",
                                     due_beat.kind, due_beat.value, due_beat.st,
                                     due_beat.len, due_beat.last);
                            $display("               got kind=%0d byte=%02h st=%0d len=%0d last=%0d",
                                     seen_beat.kind, seen_beat.value, seen_beat.st,
                                     seen_beat.len, seen_beat.last);
                        end
                        mismatches++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed items, then random segments
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] slaves_val;
        logic [TICK_W-1:0]     tmo_val;

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_idx                 = CFG_SLAVE_TABLE;
        cfg_data                = '0;
        req_ch.valid            = 1'b0;
        req_ch.operation        = '0;
        req_ch.slave_select     = '0;
        req_ch.register_address = '0;
        req_ch.register_count   = '0;
        req_ch.data_byte        = '0;
        rsp_ch.ready            = 1'b0;

        link_phase    = PH_IDLE;
        tx_crc        = CRC_INIT;
        rx_crc        = CRC_INIT;
        bytes_left    = '0;
        reply_len     = '0;
        ticks_seen    = '0;
        cur_slave     = '0;
        slave_table   = '0;
        timeout_limit = TIMEOUT_RESET;

        // sender idles 28 %, receiver stalls 81 %
        send_idle_pct  = 28;
        recv_stall_pct = 81;

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, registers at reset values (all slave addresses zero)
        for (int op = OP_TICK + 1; op <= OP_TOP; op++)
            queue_filler(OP_W'(op), 8'($urandom));          // unknown operations
        queue_filler(OP_TICK, 8'h00);                       // idle: ignored
        queue_filler(OP_RX_BYTE, 8'hFF);
        queue_filler(OP_PAYLOAD, 8'hFF);
        queue_item(OP_START_READ, '0, '0, '0, '0);           // count clamps up to 1
        queue_item(OP_START_WRITE, '1, '1, '1, '1);          // busy
        queue_filler(OP_PAYLOAD, 8'hA5);                    // ignored in read wait
        queue_filler(OP_TICK, '0);
        reply_bytes.delete();
        add_reply(8'h00);
        add_reply(FC_READ);
        add_reply(8'h02);
        add_reply(8'h00);
        add_reply(8'hFF);
        close_reply();
        foreach (reply_bytes[i]) queue_filler(OP_RX_BYTE, reply_bytes[i]);
        queue_item(OP_START_WRITE, '1, '1, CNT_W'(1), '0);   // top select and address
        queue_filler(OP_RX_BYTE, 8'h00);                    // ignored while collecting
        queue_filler(OP_TICK, '1);
        queue_filler(OP_START_READ, '0);                    // busy
        queue_filler(OP_PAYLOAD, 8'hFF);
        queue_filler(OP_PAYLOAD, 8'h00);
        queue_filler(OP_RX_BYTE, 8'h5A);                    // wrong address: no ack
        settle_link();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // idle pattern swaps after three segments, then no idling
            case (seg / 3)
                0: begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 81;
                end
                1: begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 28;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            slaves_val = {$urandom, $urandom};
            case (seg)
                0: begin
                    slaves_val = '1;
                    tmo_val    = TICK_W'(1);
                end
                1: tmo_val = TICK_MAX;
                2: tmo_val = TICK_W'($urandom_range(2, 40));
                3: tmo_val = TIMEOUT_RESET;
                4: begin
                    slaves_val = '0;
                    tmo_val    = TICK_W'(3);
                end
                default: tmo_val = TICK_W'($urandom_range(1, TMO_WINDOW));
            endcase
            write_reg(CFG_SLAVE_TABLE, slaves_val);
            // upper bits of the timeout write are don't-care
            write_reg(CFG_TIMEOUT, {$urandom, 8'($urandom), tmo_val});
            if (seg == 0) begin
                // count above range clamps to the maximum; second tick times out
                queue_item(OP_START_READ, SEL_W'(3), ADDR_W'($urandom), '1, 8'($urandom));
                queue_filler(OP_TICK, 8'($urandom));
                queue_filler(OP_TICK, 8'($urandom));
            end
            queue_random_traffic(SEG_ITEMS);
            settle_link();
        end

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
